/* src/tefdr_pkg.sv */
// Shared types and constants for the touch event queue.
package tefdr_pkg;

    localparam int COORD_W = 16;
    localparam int CODE_W  = 8;
    localparam int ENTRY_W = CODE_W + 2 * COORD_W;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 3;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [CFG_W-1:0]     t_cfg_data;

    // Configuration register indexes
    localparam t_cfg_idx CFG_ROTATE_ENABLE   = 3'd0;
    localparam t_cfg_idx CFG_RECT_LEFT       = 3'd1;
    localparam t_cfg_idx CFG_RECT_TOP        = 3'd2;
    localparam t_cfg_idx CFG_RECT_WIDTH      = 3'd3;
    localparam t_cfg_idx CFG_RECT_HEIGHT     = 3'd4;
    localparam t_cfg_idx CFG_IDLE_EVENT_CODE = 3'd5;

    // Request function codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    // One stored touch record
    typedef struct packed {
        logic [CODE_W-1:0]  ev;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } t_rec;

    // Input request
    typedef struct packed {
        logic               func;
        logic [CODE_W-1:0]  event_code;
        logic [COORD_W-1:0] x_coord;
        logic [COORD_W-1:0] y_coord;
    } t_req;

    // Result
    typedef struct packed {
        logic               read_valid;
        logic [CODE_W-1:0]  out_event;
        logic [COORD_W-1:0] out_x;
        logic [COORD_W-1:0] out_y;
        logic               notify;
        logic               dropped;
    } t_rsp;

endpackage

/* src/tefdr_chan_if.sv */
// Valid/ready channel carrying one item of any payload type.
interface tefdr_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* src/touch_event_fifo_dedup_rotate_unit.sv */
// Touch event queue: mirroring, duplicate suppression and a ring in RAM.
//
//  channel  | dir | handshake           | carries
//  ---------+-----+---------------------+------------------------------------
//  i_req    | in  | valid/ready         | func, event_code, x_coord, y_coord
//  o_rsp    | out | valid/ready         | read_valid, event, x, y, notify,
//           |     |                     | dropped
//  i_cfg_*  | in  | write enable only   | register index and data
//
// A write or an empty read is answered from the output register, loaded in the
// cycle after the request is accepted. A read that pops first reads the ring
// RAM, whose read data is registered; the ST_POP state then loads its result.
// Reset clears pointers, the last-record flag and control; the RAM is not
// cleared. The request side stalls while a result waits untaken and while a pop
// waits in ST_POP for the RAM data.
module touch_event_fifo_dedup_rotate_unit #(
    parameter int DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    tefdr_chan_if.sink          i_req,
    tefdr_chan_if.source        o_rsp,
    input  logic                i_cfg_we,
    input  tefdr_pkg::t_cfg_idx i_cfg_idx,
    input  tefdr_pkg::t_cfg_data i_cfg_wdata
);
    import tefdr_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    typedef enum logic {
        ST_IDLE,
        ST_POP
    } t_state;

    t_state              r_state;
    logic [IDX_W-1:0]    r_head;
    logic [IDX_W-1:0]    r_tail;
    t_rec                r_last;
    logic                r_last_known;
    t_rsp                r_out;
    logic                r_out_valid;

    // Configuration registers
    logic                r_rot_en;
    logic [COORD_W-1:0]  r_left;
    logic [COORD_W-1:0]  r_top;
    logic [COORD_W-1:0]  r_width;
    logic [COORD_W-1:0]  r_height;
    logic [CODE_W-1:0]   r_idle_code;

    t_req                w_req;
    logic                w_accept;
    logic                w_out_free;
    logic                w_in_x;
    logic                w_in_y;
    t_rec                w_rec;
    t_rec                w_cur_last;
    logic                w_dup;
    logic [IDX_W-1:0]    w_next_tail;
    logic [IDX_W-1:0]    w_next_head;
    logic                w_full;
    logic                w_empty;
    logic                w_ram_we;
    logic                w_ram_re;
    logic [ENTRY_W-1:0]  w_ram_rdata;
    t_rec                w_pop_rec;
    t_rsp                w_rsp;

    assign w_req      = i_req.payload;
    assign w_out_free = !r_out_valid || o_rsp.ready;
    assign i_req.ready = (r_state == ST_IDLE) && w_out_free;
    assign w_accept   = i_req.valid && i_req.ready;

    // Rectangle test, sums kept at 17 bits so they do not wrap
    always_comb begin
        w_in_x = ({1'b0, w_req.x_coord} >= {1'b0, r_left}) &&
                 ({1'b0, w_req.x_coord} < ({1'b0, r_left} + {1'b0, r_width}));
        w_in_y = ({1'b0, w_req.y_coord} >= {1'b0, r_top}) &&
                 ({1'b0, w_req.y_coord} < ({1'b0, r_top} + {1'b0, r_height}));
    end

    // Mirror points inside the rectangle when rotate-enable is set; result is taken modulo 2^16
    always_comb begin
        w_rec.ev = w_req.event_code;
        w_rec.x  = w_req.x_coord;
        w_rec.y  = w_req.y_coord;
        if (r_rot_en && w_in_x && w_in_y) begin
            w_rec.x = r_left + r_left + r_width - 16'd1 - w_req.x_coord;
            w_rec.y = r_top + r_top + r_height - 16'd1 - w_req.y_coord;
        end
    end

    // Last record, or the idle code before any write
    always_comb begin
        if (r_last_known) begin
            w_cur_last = r_last;
        end else begin
            w_cur_last.ev = r_idle_code;
            w_cur_last.x  = '0;
            w_cur_last.y  = '0;
        end
    end

    assign w_dup       = (w_rec == w_cur_last);
    assign w_next_tail = (r_tail == LAST_IDX) ? '0 : r_tail + 1'b1;
    assign w_next_head = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
    assign w_full      = (w_next_tail == r_head);
    assign w_empty     = (r_head == r_tail);

    assign w_ram_we = w_accept && (w_req.func == FUNC_WRITE) && !w_dup && !w_full;
    assign w_ram_re = w_accept && (w_req.func == FUNC_READ) && !w_empty;

    // Result of a write or an empty read
    always_comb begin
        w_rsp = '0;
        if (w_req.func == FUNC_WRITE) begin
            if (!w_dup) begin
                w_rsp.dropped = w_full;
                w_rsp.notify  = !w_full;
            end
        end else begin
            w_rsp.out_event = w_cur_last.ev;
            w_rsp.out_x     = w_cur_last.x;
            w_rsp.out_y     = w_cur_last.y;
        end
    end

    tefdr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ring_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_ram_we),
        .i_wr_addr (r_tail),
        .i_wr_data (w_rec),
        .i_rd_en   (w_ram_re),
        .i_rd_addr (r_head),
        .o_rd_data (w_ram_rdata)
    );

    assign w_pop_rec = w_ram_rdata;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot_en    <= 1'b0;
            r_left      <= '0;
            r_top       <= '0;
            r_width     <= '0;
            r_height    <= '0;
            r_idle_code <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ROTATE_ENABLE:   r_rot_en    <= i_cfg_wdata[0];
                CFG_RECT_LEFT:       r_left      <= i_cfg_wdata;
                CFG_RECT_TOP:        r_top       <= i_cfg_wdata;
                CFG_RECT_WIDTH:      r_width     <= i_cfg_wdata;
                CFG_RECT_HEIGHT:     r_height    <= i_cfg_wdata;
                CFG_IDLE_EVENT_CODE: r_idle_code <= i_cfg_wdata[CODE_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer, ring pointers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_head       <= '0;
            r_tail       <= '0;
            r_last_known <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_ram_re) begin
                        // Pop: result comes once RAM data is back
                        r_out_valid <= 1'b0;
                        r_head      <= w_next_head;
                        r_state     <= ST_POP;
                    end else if (w_accept) begin
                        r_out       <= w_rsp;
                        r_out_valid <= 1'b1;
                        if ((w_req.func == FUNC_WRITE) && !w_dup) begin
                            r_last       <= w_rec;
                            r_last_known <= 1'b1;
                            if (!w_full) begin
                                r_tail <= w_next_tail;
                            end
                        end
                    end else if (o_rsp.ready) begin
                        r_out_valid <= 1'b0;
                    end
                end
                ST_POP: begin
                    r_out.read_valid <= 1'b1;
                    r_out.out_event  <= w_pop_rec.ev;
                    r_out.out_x      <= w_pop_rec.x;
                    r_out.out_y      <= w_pop_rec.y;
                    r_out.notify     <= 1'b0;
                    r_out.dropped    <= 1'b0;
                    r_out_valid      <= 1'b1;
                    r_state          <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

`ifndef SYNTHESIS
    // The output register is free while a pop waits on the RAM
    a_pop_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_POP) |-> !r_out_valid)
        else $error("output register busy during pop");

    // A pop always delivers a valid read result next cycle
    a_pop_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_POP) |=> (r_out_valid && r_out.read_valid))
        else $error("pop did not deliver a read result");

    // Read results carry no write flags, and writes never both queue and drop
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.notify && r_out.dropped) &&
                        !(r_out.read_valid && (r_out.notify || r_out.dropped)))
        else $error("inconsistent result flags");
`endif

endmodule

/* src/tefdr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module tefdr_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule
